>>> src/cfol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfol_pkg
// Shared types, constants and the rounding helper of the cascaded low-pass.
// ----------------------------------------------------------------------------
package cfol_pkg;

	localparam int COEFF_W    = 32;                      // coefficient and state width
	localparam int STAGES_W   = 4;                       // stages_in_use register width
	localparam int CFG_IDX_W  = 2;                       // register index width
	localparam int CFG_DATA_W = 32;                      // widest register
	localparam int OP_A_W     = COEFF_W + 1;             // room for x + x_prev
	localparam int PROD_W     = OP_A_W + COEFF_W;
	localparam int ACC_W      = PROD_W + 1;              // sum of two products

	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDFORWARD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STAGES      = 2'd3;

	localparam logic signed [COEFF_W-1:0] GAIN_RESET = 32'sd16777216;

	typedef struct packed {
		logic mul_en;    // register a new product
		logic acc_load;  // accumulator takes the product
		logic acc_add;   // accumulator adds the product
	} mac_ctl_t;

	// Round half up by sh bits and saturate to signed 32 bits.
	function automatic logic signed [COEFF_W-1:0] round_sat32(
		input logic signed [ACC_W-1:0] acc,
		input int unsigned             sh
	);
		logic signed [ACC_W:0] t;
		logic signed [ACC_W:0] hi;
		logic signed [ACC_W:0] lo;
		hi = (ACC_W+1)'(32'sh7fffffff);
		lo = -hi - (ACC_W+1)'(1);
		t  = (ACC_W+1)'(acc) + ((ACC_W+1)'(1) <<< (sh - 1));
		t  = t >>> sh;
		if (t > hi) begin
			return hi[COEFF_W-1:0];
		end else if (t < lo) begin
			return lo[COEFF_W-1:0];
		end
		return t[COEFF_W-1:0];
	endfunction

endpackage

>>> src/cfol_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfol_mac
// Shared multiply-accumulate unit: registered product, then accumulator.
// ----------------------------------------------------------------------------
module cfol_mac import cfol_pkg::*; (
	input  logic                      clk,
	input  mac_ctl_t                  ctl,
	input  logic signed [OP_A_W-1:0]  op_a,
	input  logic signed [COEFF_W-1:0] op_b,
	output logic signed [ACC_W-1:0]   acc
);

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_s2;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= op_a * op_b;
		end
		if (ctl.acc_load) begin
			acc_s2 <= ACC_W'(prod_s1);
		end else if (ctl.acc_add) begin
			acc_s2 <= acc_s2 + ACC_W'(prod_s1);
		end
	end

	assign acc = acc_s2;

endmodule

>>> src/cascaded_first_order_lowpass_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_first_order_lowpass_top
// Gain stage followed by a cascade of first-order bilinear low-pass sections.
// ----------------------------------------------------------------------------
// Each input word is one Q1.23 audio sample. It is scaled by input_gain
// (Q8.24) and then run through stages_in_use identical sections, each
// computing y = c1*y_prev + c2*(x + x_prev) in Q8.24 with round-half-up and
// saturation to 32 bits; values above MAX_STAGES act as MAX_STAGES, and zero
// sections pass the scaled sample straight through. The result word is the
// last active section's value, rounded and saturated back to SAMPLE_BITS.
// All arithmetic goes through a single multiply-accumulate unit with a
// registered product and a registered accumulator. For each accepted
// sample the gain step multiplies, loads the product and rounds; each
// section then multiplies c2 by (x + x_prev), multiplies c1 by y_prev while
// loading the first product, adds the second product and rounds; a final
// hand-over step moves the result to the output register, waiting while
// the previous result is still there to be taken; the next sample is only
// taken once the block is back in idle. The block takes one sample at a
// time; s_axis_tready is high only while it is idle, but a finished result
// sits in an output register, so the next sample can be accepted while the
// previous result still waits to be taken. The
// previous-sample store has a valid bit per entry, cleared by reset, so no
// clearing pass is needed after reset. Sections that are switched off keep
// their stored values and resume with them. Registers are written through a
// plain write port and must only be changed while the block is idle.
// ----------------------------------------------------------------------------
module cascaded_first_order_lowpass_top import cfol_pkg::*; #(
	parameter int MAX_STAGES  = 8,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [CFG_IDX_W-1:0]           cfg_addr,
	input  logic [CFG_DATA_W-1:0]          cfg_wdata,
	// input stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,  // [SAMPLE_BITS-1:0] sample_in
	// output stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata   // [SAMPLE_BITS-1:0] sample_out
);

	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int DEPTH   = MAX_STAGES + 1;
	localparam int AW      = $clog2(DEPTH);

	// Output conversion from Q8.24 to Q1.(SAMPLE_BITS-1).
	localparam int OUT_W   = COEFF_W + 9;
	localparam int OUT_RSH = (SAMPLE_BITS < 25) ? 25 - SAMPLE_BITS : 0;
	localparam int OUT_LSH = (SAMPLE_BITS > 25) ? SAMPLE_BITS - 25 : 0;
	localparam logic signed [OUT_W-1:0] OUT_HALF =
		(OUT_RSH > 0) ? (OUT_W'(1) <<< (OUT_RSH - 1)) : OUT_W'(0);
	localparam logic signed [OUT_W-1:0] OUT_MAX =
		(OUT_W'(1) <<< (SAMPLE_BITS - 1)) - OUT_W'(1);
	localparam logic signed [OUT_W-1:0] OUT_MIN = -OUT_MAX - OUT_W'(1);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a sample
	localparam logic [2:0] ST_MG   = 3'd1;  // multiply sample by gain
	localparam logic [2:0] ST_AG   = 3'd2;  // load gain product
	localparam logic [2:0] ST_MA   = 3'd3;  // multiply c2 by (x + x_prev)
	localparam logic [2:0] ST_MB   = 3'd4;  // multiply c1 by y_prev, load first product
	localparam logic [2:0] ST_AC   = 3'd5;  // add second product
	localparam logic [2:0] ST_RND  = 3'd6;  // round, saturate, store
	localparam logic [2:0] ST_OUT  = 3'd7;  // hand the result to the output register

	// Registers.
	logic [2:0]                    state_q;
	logic [AW-1:0]                 k_q;       // section being worked on, 0 for the gain step
	logic [AW-1:0]                 order_q;   // sections in use for this sample
	logic signed [COEFF_W-1:0]     fb_q;
	logic signed [COEFF_W-1:0]     ff_q;
	logic signed [COEFF_W-1:0]     gain_q;
	logic [STAGES_W-1:0]           stages_q;
	logic [DEPTH-1:0]              vld_q;
	logic                          rvld_q;
	logic                          m_tvalid_q;
	logic signed [SAMPLE_BITS-1:0] x_in_q;
	logic signed [COEFF_W-1:0]     x_q;       // current section input, finally the result
	logic signed [COEFF_W-1:0]     xp_q;      // previous value of the current section input
	logic signed [COEFF_W-1:0]     yp_q;      // previous output of the current section
	logic signed [COEFF_W-1:0]     rdata_q;
	logic [SAMPLE_BITS-1:0]        m_data_q;
	logic signed [COEFF_W-1:0]     mem [DEPTH];

	// Combinational signals.
	mac_ctl_t                      mac_ctl;
	logic signed [OP_A_W-1:0]      op_a;
	logic signed [COEFF_W-1:0]     op_b;
	logic signed [ACC_W-1:0]       acc;
	logic signed [COEFF_W-1:0]     rnd_y;
	logic signed [COEFF_W-1:0]     yprev;
	logic [AW-1:0]                 rd_addr;
	logic [AW-1:0]                 eff_order;
	logic                          in_acc;
	logic                          out_free;
	logic                          last_sec;
	logic signed [OUT_W-1:0]       out_wide;
	logic [SAMPLE_BITS-1:0]        out_sat;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !m_tvalid_q || m_axis_tready;
	assign last_sec  = (k_q == order_q);
	assign eff_order = (int'(stages_q) > MAX_STAGES) ? AW'(MAX_STAGES) : AW'(stages_q);
	assign yprev     = rvld_q ? rdata_q : '0;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = TDATA_W'(m_data_q);

	// The gain step rounds away the sample's fraction bits; sections drop 30 bits.
	assign rnd_y = (k_q == '0) ? round_sat32(acc, SAMPLE_BITS - 1) : round_sat32(acc, 30);

	// The next section's stored output is fetched while the current one rounds.
	always_comb begin
		case (state_q)
			ST_IDLE: rd_addr = '0;
			ST_RND:  rd_addr = last_sec ? k_q : k_q + AW'(1);
			default: rd_addr = k_q;
		endcase
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mac_ctl = '0;
		op_a    = '0;
		op_b    = '0;
		case (state_q)
			ST_MG: begin
				mac_ctl.mul_en = 1'b1;
				op_a           = OP_A_W'(x_in_q);
				op_b           = gain_q;
			end
			ST_AG: begin
				mac_ctl.acc_load = 1'b1;
			end
			ST_MA: begin
				mac_ctl.mul_en = 1'b1;
				op_a           = OP_A_W'(x_q) + OP_A_W'(xp_q);
				op_b           = ff_q;
			end
			ST_MB: begin
				mac_ctl.mul_en   = 1'b1;
				mac_ctl.acc_load = 1'b1;
				op_a             = OP_A_W'(yp_q);
				op_b             = fb_q;
			end
			ST_AC: begin
				mac_ctl.acc_add = 1'b1;
			end
			default: ;
		endcase
	end

	cfol_mac u_mac (
		.clk  (clk),
		.ctl  (mac_ctl),
		.op_a (op_a),
		.op_b (op_b),
		.acc  (acc)
	);

	// Conversion of the final Q8.24 value to the output sample format.
	always_comb begin
		out_wide = ((OUT_W'(x_q) + OUT_HALF) >>> OUT_RSH) <<< OUT_LSH;
		if (out_wide > OUT_MAX) begin
			out_sat = OUT_MAX[SAMPLE_BITS-1:0];
		end else if (out_wide < OUT_MIN) begin
			out_sat = OUT_MIN[SAMPLE_BITS-1:0];
		end else begin
			out_sat = out_wide[SAMPLE_BITS-1:0];
		end
	end

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			k_q        <= '0;
			order_q    <= '0;
			fb_q       <= '0;
			ff_q       <= '0;
			gain_q     <= GAIN_RESET;
			stages_q   <= STAGES_W'(1);
			vld_q      <= '0;
			rvld_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[rd_addr];
			if (cfg_we) begin
				case (cfg_addr)
					REG_FEEDBACK:    fb_q     <= cfg_wdata[COEFF_W-1:0];
					REG_FEEDFORWARD: ff_q     <= cfg_wdata[COEFF_W-1:0];
					REG_GAIN:        gain_q   <= cfg_wdata[COEFF_W-1:0];
					REG_STAGES:      stages_q <= cfg_wdata[STAGES_W-1:0];
					default: ;
				endcase
			end
			// A new result takes the output register as the old one leaves it.
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						k_q     <= '0;
						order_q <= eff_order;
						state_q <= ST_MG;
					end
				end
				ST_MG:  state_q <= ST_AG;
				ST_AG:  state_q <= ST_RND;
				ST_MA:  state_q <= ST_MB;
				ST_MB:  state_q <= ST_AC;
				ST_AC:  state_q <= ST_RND;
				ST_RND: begin
					vld_q[k_q] <= 1'b1;
					if (last_sec) begin
						state_q <= ST_OUT;
					end else begin
						k_q     <= k_q + AW'(1);
						state_q <= ST_MA;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers and the previous-sample store.
	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
		if (in_acc) begin
			x_in_q <= s_axis_tdata[SAMPLE_BITS-1:0];
		end
		if (state_q == ST_MG || state_q == ST_MA) begin
			yp_q <= yprev;
		end
		if (state_q == ST_RND) begin
			mem[k_q] <= rnd_y;
			xp_q     <= yp_q;
			x_q      <= rnd_y;
		end
		if (state_q == ST_OUT && out_free) begin
			m_data_q <= out_sat;
		end
	end

`ifndef SYNTH
	// The section counter never runs past the number of sections in use.
	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (k_q <= order_q))
		else $error("section counter beyond active order");

	// An accepted sample always starts with the gain step.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_MG && k_q == '0))
		else $error("accepted sample did not start the gain step");

	// A finished result reaches the output register and frees the block.
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (m_tvalid_q && state_q == ST_IDLE))
		else $error("result not delivered to the output register");

	// A new result is only ever raised from the hand-over state.
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_OUT))
		else $error("output valid raised outside the hand-over state");
`endif

endmodule
